### sv/lpfd_pkg.sv
// lpfd_pkg: shared constants and types of the length-prefixed frame deframer
// result kind codes, length field geometry and the result struct
// no dependencies; lpfd_core and the top level use it
package lpfd_pkg;

  localparam int unsigned LEN_FIELD_BYTES = 4;
  localparam int unsigned LEN_W           = 32;
  localparam int unsigned CNT_W           = 2;

  localparam logic [CNT_W-1:0] LAST_FIELD_BYTE = CNT_W'(LEN_FIELD_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_FIELD_SIZE  = LEN_W'(LEN_FIELD_BYTES);
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 32'd65536;

  localparam logic [1:0] K_HEADER  = 2'd0;
  localparam logic [1:0] K_PAYLOAD = 2'd1;
  localparam logic [1:0] K_EMPTY   = 2'd2;
  localparam logic [1:0] K_ERROR   = 2'd3;

  typedef struct packed {
    logic       has_result;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       header_end;
    logic       frame_end;
  } result_t;

endpackage

### sv/lpfd_if.sv
// lpfd_if: valid/ready channel interfaces of the deframer
// input channel carries one raw word, result channel one tagged result
// depends on nothing
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic       header_end;
  logic       frame_end;

  modport source (output valid, output kind, output byte_out, output header_end,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input byte_out, input header_end,
                  input frame_end, output ready);
endinterface

### sv/lpfd_core.sv
// lpfd_core: frame parsing state machine, one word per step
// gives the result of the presented word combinationally, updates state on step
// depends on lpfd_pkg
module lpfd_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               byte_in,
  input  logic [lpfd_pkg::LEN_W-1:0] max_frame,
  output lpfd_pkg::result_t        res
);

  localparam logic [2:0] PH_TOTAL   = 3'd0;
  localparam logic [2:0] PH_HLEN    = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  logic [2:0]                       phase_r, phase_nxt;
  logic [lpfd_pkg::CNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [lpfd_pkg::LEN_W-1:0]       total_r, total_nxt;
  logic [lpfd_pkg::LEN_W-1:0]       hlen_r, hlen_nxt;
  logic [lpfd_pkg::LEN_W-1:0]       hrem_r, hrem_nxt;
  logic [lpfd_pkg::LEN_W-1:0]       prem_r, prem_nxt;

  logic                             last_byte;
  logic [lpfd_pkg::LEN_W-1:0]       total_shift;
  logic [lpfd_pkg::LEN_W-1:0]       hlen_shift;
  logic [lpfd_pkg::LEN_W-1:0]       body_room;
  logic                             hdr_last;

  assign last_byte   = (fcnt_r == lpfd_pkg::LAST_FIELD_BYTE);
  assign total_shift = {total_r[lpfd_pkg::LEN_W-9:0], byte_in};
  assign hlen_shift  = {hlen_r[lpfd_pkg::LEN_W-9:0], byte_in};
  assign body_room   = total_r - lpfd_pkg::LEN_FIELD_SIZE;
  assign hdr_last    = (hrem_r == lpfd_pkg::LEN_W'(1));

  always_comb begin
    phase_nxt = phase_r;
    fcnt_nxt  = fcnt_r;
    total_nxt = total_r;
    hlen_nxt  = hlen_r;
    hrem_nxt  = hrem_r;
    prem_nxt  = prem_r;
    res       = '0;
    case (phase_r)
      PH_TOTAL: begin
        total_nxt = total_shift;
        if (!last_byte) begin
          fcnt_nxt = fcnt_r + lpfd_pkg::CNT_W'(1);
        end else begin
          fcnt_nxt = '0;
          if (total_shift < lpfd_pkg::LEN_FIELD_SIZE || total_shift > max_frame) begin
            phase_nxt      = PH_ERROR;
            res.has_result = 1'b1;
            res.kind       = lpfd_pkg::K_ERROR;
            res.frame_end  = 1'b1;
          end else begin
            phase_nxt = PH_HLEN;
          end
        end
      end
      PH_HLEN: begin
        hlen_nxt = hlen_shift;
        if (!last_byte) begin
          fcnt_nxt = fcnt_r + lpfd_pkg::CNT_W'(1);
        end else begin
          fcnt_nxt = '0;
          if (hlen_shift > body_room) begin
            phase_nxt      = PH_ERROR;
            res.has_result = 1'b1;
            res.kind       = lpfd_pkg::K_ERROR;
            res.frame_end  = 1'b1;
          end else begin
            hrem_nxt  = hlen_shift;
            prem_nxt  = body_room - hlen_shift;
            total_nxt = '0;
            hlen_nxt  = '0;
            // empty body: total counts only the header length field
            if (hlen_shift == '0 && total_r == lpfd_pkg::LEN_FIELD_SIZE) begin
              phase_nxt      = PH_TOTAL;
              res.has_result = 1'b1;
              res.kind       = lpfd_pkg::K_EMPTY;
              res.frame_end  = 1'b1;
            end else if (hlen_shift != '0) begin
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_HEADER: begin
        hrem_nxt       = hrem_r - lpfd_pkg::LEN_W'(1);
        res.has_result = 1'b1;
        res.kind       = lpfd_pkg::K_HEADER;
        res.byte_out   = byte_in;
        res.header_end = hdr_last;
        res.frame_end  = hdr_last && (prem_r == '0);
        if (hdr_last) begin
          phase_nxt = (prem_r == '0) ? PH_TOTAL : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        prem_nxt       = prem_r - lpfd_pkg::LEN_W'(1);
        res.has_result = 1'b1;
        res.kind       = lpfd_pkg::K_PAYLOAD;
        res.byte_out   = byte_in;
        res.frame_end  = (prem_r == lpfd_pkg::LEN_W'(1));
        if (prem_r == lpfd_pkg::LEN_W'(1)) begin
          phase_nxt = PH_TOTAL;
        end
      end
      default: begin
        // error phase: words are dropped until reset
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOTAL;
      fcnt_r  <= '0;
      total_r <= '0;
      hlen_r  <= '0;
      hrem_r  <= '0;
      prem_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      total_r <= total_nxt;
      hlen_r  <= hlen_nxt;
      hrem_r  <= hrem_nxt;
      prem_r  <= prem_nxt;
    end
  end

endmodule

### sv/length_prefixed_frame_deframer.sv
// length_prefixed_frame_deframer: top level, input register, parser, result register
// depends on lpfd_pkg, lpfd_in_if, lpfd_out_if and lpfd_core
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      byte_in[7:0]
//   out_ch    out   valid/ready      kind[1:0] byte_out[7:0] header_end frame_end
//   cfg       in    cfg_we           cfg_wdata[31:0] (max_frame_bytes)
//
// one word per cycle sustained while out_ch.ready does not hold a result; an accepted word
// passes the input register and then the result register before its result shows on out_ch
// the path is input register -> parser state machine -> result register
// a full result register held by out_ch.ready stalls only words that make a result
// reset (rst_n low, synchronous) returns to the total length field, limit 65536
module length_prefixed_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  lpfd_in_if.sink                     in_ch,
  lpfd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [lpfd_pkg::LEN_W-1:0]  cfg_wdata
);

  logic [lpfd_pkg::LEN_W-1:0] max_frame_r;
  logic                       s1_valid_r;
  logic [7:0]                 s1_byte_r;
  logic                       out_valid_r;
  lpfd_pkg::result_t          out_res_r;
  lpfd_pkg::result_t          core_res;
  logic                       out_free;
  logic                       s1_fire;
  logic                       in_fire;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && (!core_res.has_result || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= lpfd_pkg::MAX_FRAME_RESET;
    end else if (cfg_we) begin
      max_frame_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.byte_in;
    end
  end

  lpfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .byte_in   (s1_byte_r),
    .max_frame (max_frame_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && core_res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && core_res.has_result) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_res_r.kind;
  assign out_ch.byte_out   = out_res_r.byte_out;
  assign out_ch.header_end = out_res_r.header_end;
  assign out_ch.frame_end  = out_res_r.frame_end;

  // empty frame and error results always close a frame
  a_close_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == lpfd_pkg::K_EMPTY ||
                    out_res_r.kind == lpfd_pkg::K_ERROR) |-> out_res_r.frame_end)
    else $error("empty or error result without frame_end");

  a_hdr_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.header_end |-> out_res_r.kind == lpfd_pkg::K_HEADER)
    else $error("header_end on a non-header result");

  // nothing follows an error until reset
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && out_res_r.kind == lpfd_pkg::K_ERROR |=> !out_valid_r)
    else $error("result after frame error");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a stalled word");

endmodule
